@@ rtl/mfrc_pkg.sv @@
// shared types, constants and crc function for the marker frame receiver
package mfrc_pkg;

	localparam int unsigned MAX_FRAME = 256;
	localparam logic [7:0] OVF_POS = 8'(MAX_FRAME - 3);

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [7:0] MARK0 = 8'h3E;
	localparam logic [7:0] MARK1 = 8'h45;
	localparam logic [7:0] MARK2 = 8'h54;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);

	// front-end frame phase
	typedef enum logic [1:0] {
		PH_COLLECT = 2'd0,
		PH_CRC_HI  = 2'd1,
		PH_CRC_LO  = 2'd2
	} phase_t;

	// what the back end does with a byte
	typedef enum logic [1:0] {
		OP_DATA     = 2'd0,
		OP_CRC_HI   = 2'd1,
		OP_CRC_LO   = 2'd2,
		OP_OVERFLOW = 2'd3
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
		logic [7:0] pos;
	} entry_t;

	// crc-16/modbus, one byte, reflected
	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

@@ rtl/mfrc_front.sv @@
// front end: marker matcher, frame position and phase, byte classification
module mfrc_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  logic [7:0]      in_byte,
	output logic            q_push,
	output mfrc_pkg::entry_t q_entry,
	input  logic            q_full
);
	import mfrc_pkg::*;

	phase_t      phase_q, phase_d;
	logic [1:0]  mark_q, mark_d;
	logic [7:0]  cnt_q, cnt_d;
	logic        accept;

	assign full   = q_full;
	assign accept = push && !q_full;
	assign q_push = accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_COLLECT;
			mark_q  <= 2'd0;
			cnt_q   <= 8'd0;
		end else if (accept) begin
			phase_q <= phase_d;
			mark_q  <= mark_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		logic [1:0] mark_nx;
		logic       done;
		q_entry.data = in_byte;
		q_entry.pos  = cnt_q;
		q_entry.op   = OP_DATA;
		phase_d      = phase_q;
		mark_d       = mark_q;
		cnt_d        = cnt_q + 8'd1;
		mark_nx      = 2'd0;
		done         = 1'b0;
		unique case (phase_q)
			PH_CRC_HI: begin
				q_entry.op = OP_CRC_HI;
				phase_d    = PH_CRC_LO;
			end
			PH_CRC_LO: begin
				q_entry.op = OP_CRC_LO;
				phase_d    = PH_COLLECT;
				mark_d     = 2'd0;
				cnt_d      = 8'd0;
			end
			default: begin
				// streaming match of the end marker
				unique case (mark_q)
					2'd0: mark_nx = (in_byte == MARK0) ? 2'd1 : 2'd0;
					2'd1: mark_nx = (in_byte == MARK1) ? 2'd2 :
						((in_byte == MARK0) ? 2'd1 : 2'd0);
					default: begin
						done    = (in_byte == MARK2);
						mark_nx = (in_byte == MARK0) ? 2'd1 : 2'd0;
					end
				endcase
				if (done) begin
					phase_d = PH_CRC_HI;
					mark_d  = 2'd0;
				end else if (cnt_q >= OVF_POS) begin
					q_entry.op = OP_OVERFLOW;
					phase_d    = PH_COLLECT;
					mark_d     = 2'd0;
					cnt_d      = 8'd0;
				end else begin
					phase_d = PH_COLLECT;
					mark_d  = mark_nx;
				end
			end
		endcase
	end

endmodule

@@ rtl/mfrc_queue.sv @@
// short register queue between front and back end
module mfrc_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  mfrc_pkg::entry_t wr_entry,
	output logic             q_full,
	input  logic             rd,
	output mfrc_pkg::entry_t rd_entry,
	output logic             q_empty
);
	import mfrc_pkg::*;

	entry_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wp_q, rp_q;
	logic [QPTR_W:0]     cnt_q;
	logic                do_wr, do_rd;

	assign q_full   = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign q_empty  = (cnt_q == '0);
	assign do_wr    = wr && !q_full;
	assign do_rd    = rd && !q_empty;
	assign rd_entry = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= rp_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/mfrc_back.sv @@
// back end: running crc, crc compare and result register
module mfrc_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  mfrc_pkg::entry_t q_head,
	output logic             q_pop,
	output logic             empty,
	input  logic             pop,
	output logic [7:0]       out_byte,
	output logic [7:0]       position,
	output logic             frame_last,
	output logic             crc_ok,
	output logic             overflow
);
	import mfrc_pkg::*;

	logic [15:0] crc_q;
	logic        hbm_q;
	logic        valid_q;
	logic        take;

	assign take  = !q_empty && (!valid_q || pop);
	assign q_pop = take;
	assign empty = !valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q   <= CRC_INIT;
			hbm_q   <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (take) begin
				valid_q <= 1'b1;
			end else if (pop) begin
				valid_q <= 1'b0;
			end
			if (take) begin
				unique case (q_head.op)
					OP_DATA:     crc_q <= crc_update(crc_q, q_head.data);
					OP_CRC_HI:   hbm_q <= (q_head.data == crc_q[15:8]);
					OP_CRC_LO: begin
						crc_q <= CRC_INIT;
						hbm_q <= 1'b0;
					end
					OP_OVERFLOW: begin
						crc_q <= CRC_INIT;
						hbm_q <= 1'b0;
					end
					default: crc_q <= crc_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_byte   <= q_head.data;
			position   <= q_head.pos;
			frame_last <= (q_head.op == OP_CRC_LO);
			crc_ok     <= (q_head.op == OP_CRC_LO) && hbm_q
				&& (q_head.data == crc_q[7:0]);
			overflow   <= (q_head.op == OP_OVERFLOW);
		end
	end

endmodule

@@ rtl/marker_frame_receiver_crc16_check.sv @@
// top level of the marker-terminated frame receiver with crc-16/modbus check
// one byte is taken per push transaction and one result comes back per byte, in order:
// the byte itself, its position in the frame, and the flags frame_last, crc_ok and
// overflow. a frame is any run of bytes closed by the end marker ">ET" (3e 45 54)
// followed by two crc bytes, high byte first; the crc-16/modbus (init ffff, reflected
// poly a001) covers every byte up to and including the marker. the second crc byte
// carries frame_last, with crc_ok high when both crc bytes match. a frame that reaches
// position 253 without finishing its marker is dropped: that byte carries overflow and
// the next byte starts a new frame at position 0. rate is one byte per clock, both
// sides may stall on their own; a result passes through the queue and then the result
// register before it shows up on the result ports. a four-entry queue sits between the
// front end (marker matcher and frame position) and the back end (crc and compare);
// full rises once the queue and the result register are all occupied
module marker_frame_receiver_crc16_check (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_byte,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic [7:0] position,
	output logic       frame_last,
	output logic       crc_ok,
	output logic       overflow
);
	import mfrc_pkg::*;

	// front to queue
	logic   f_push;
	entry_t f_entry;
	logic   q_full;

	// queue to back
	logic   q_empty;
	logic   q_pop;
	entry_t q_head;

	// classifies each byte and tracks the frame position
	mfrc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.in_byte (in_byte),
		.q_push  (f_push),
		.q_entry (f_entry),
		.q_full  (q_full)
	);

	// decouples the two halves so each can stall independently
	mfrc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (f_push),
		.wr_entry (f_entry),
		.q_full   (q_full),
		.rd       (q_pop),
		.rd_entry (q_head),
		.q_empty  (q_empty)
	);

	// running crc, compare and the result register
	mfrc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.empty      (empty),
		.pop        (pop),
		.out_byte   (out_byte),
		.position   (position),
		.frame_last (frame_last),
		.crc_ok     (crc_ok),
		.overflow   (overflow)
	);

endmodule

@@ rtl/mfrc_checker.sv @@
// port-level checker for the frame receiver and its bind
module mfrc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic [7:0] out_byte,
	input logic [7:0] position,
	input logic       frame_last,
	input logic       crc_ok,
	input logic       overflow
);

	// crc_ok only comes with the last byte of a frame
	a_ok_with_end: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && crc_ok |-> frame_last)
		else $error("crc_ok without frame_last");

	// overflow only at the capacity limit and never on a frame end
	a_ovf_pos: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && overflow |-> (position >= 8'd253) && !frame_last)
		else $error("overflow at bad position or with frame_last");

	// a frame end needs at least marker plus high crc byte before it
	a_end_pos: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && frame_last |-> position >= 8'd4)
		else $error("frame_last too early in frame");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(out_byte) && $stable(position)
			&& $stable(frame_last) && $stable(crc_ok) && $stable(overflow))
		else $error("result changed while stalled");

endmodule

bind marker_frame_receiver_crc16_check mfrc_checker u_mfrc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.empty      (empty),
	.pop        (pop),
	.out_byte   (out_byte),
	.position   (position),
	.frame_last (frame_last),
	.crc_ok     (crc_ok),
	.overflow   (overflow)
);
